// ===== rtl/tsap_pkg.sv =====
`timescale 1ns / 1ps

package tsap_pkg;

   localparam int MAX_REQUESTS_DEFAULT = 32;

   localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;
   localparam logic [44:0] ALL_ONES_45 = 45'h1FFF_FFFF_FFFF;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BUDGET   = 2'd0;
   localparam logic [1:0] CSR_ALIASING = 2'd1;
   localparam logic [1:0] CSR_WEB      = 2'd2;
   localparam logic [1:0] CSR_POLICY   = 2'd3;

   // Outcome codes.
   localparam logic [1:0] OUTCOME_MANAGED  = 2'd0;
   localparam logic [1:0] OUTCOME_DISJOINT = 2'd1;
   localparam logic [1:0] OUTCOME_ALIAS    = 2'd2;

   typedef struct packed {
      logic        first_of_plan;
      logic        last_of_plan;
      logic [47:0] resource_identity;
      logic [31:0] resource_generation;
      logic [31:0] compatibility_key;
      logic [39:0] size_bytes;
      logic [39:0] alignment_bytes;
      logic [15:0] first_pass;
      logic [15:0] last_pass;
      logic        allow_alias;
   } req_type;

   typedef struct packed {
      logic [4:0]  request_index;
      logic [4:0]  slot_index;
      logic [39:0] committed_size;
      logic        plan_ok;
      logic [1:0]  outcome;
      logic [5:0]  slot_count;
      logic [5:0]  alias_count;
      logic [44:0] requested_bytes;
      logic [39:0] peak_bytes;
      logic        last_row;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [39:0] size;
      logic [39:0] alignment;
      logic [15:0] last_pass;
      logic        aliasable;
   } slot_entry_type;

   typedef struct packed {
      logic        ok;
      logic [39:0] value;
   } align_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DUP_RD,
      S_DUP_CMP,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_NEW,
      S_GROW_A,
      S_GROW_B,
      S_GROW_C,
      S_COMMIT,
      S_END,
      S_FAIL_OUT,
      S_EMIT_RD,
      S_EMIT_SZ,
      S_EMIT_OUT
   } state_type;

   // Aligns size up to a power of two; flags bad inputs or a sum above 40 bits.
   function automatic align_type align_up(input logic [39:0] size, input logic [39:0] align);
      align_type   res;
      logic [40:0] mask;
      logic [40:0] sum;
      mask = {1'b0, align} - 41'd1;
      sum = {1'b0, size} + mask;
      res.value = sum[39:0] & ~mask[39:0];
      res.ok = (size != 40'd0) && (align != 40'd0) && ((align & mask[39:0]) == 40'd0)
               && !sum[40];
      return res;
   endfunction

endpackage

// ===== rtl/tsap_slot_mem.sv =====
`timescale 1ns / 1ps

module tsap_slot_mem #(
   parameter int DEPTH = tsap_pkg::MAX_REQUESTS_DEFAULT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  tsap_pkg::slot_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output tsap_pkg::slot_entry_type rd_data
);

   tsap_pkg::slot_entry_type mem [DEPTH];
   tsap_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/transient_slot_alias_planner_top.sv =====
`timescale 1ns / 1ps

// Plans memory slots for a run of resource requests, one request at a time. Each accepted
// request is checked, then searched for a duplicate identity among the earlier requests of
// the plan. With aliasing on and allowed by the request, a first-fit search then looks for a
// slot to reuse, which may be grown; otherwise a new slot is opened. Both searches walk
// a single-ported table one entry per read. A request that fails its checks, or arrives
// after a failure, skips the searches. The last request of a plan then emits a result row
// for each committed request (a table read for the slot number and one for its size), or
// one failure row. Each row also waits until the output register is free. The block stalls
// its input while it works.
module transient_slot_alias_planner_top #(
   parameter int MAX_REQUESTS = tsap_pkg::MAX_REQUESTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsap_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsap_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [39:0]       csr_wdata
);

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

   tsap_pkg::state_type state_ff, state_in;

   logic [39:0] budget_ff;
   logic        aliasing_ff;
   logic        web_ff;
   logic [31:0] policy_ff;

   tsap_pkg::req_type req_ff;
   logic [39:0]       committed_ff;
   logic [39:0]       ns_ff;
   logic [39:0]       na_ff;
   logic [39:0]       delta_ff;
   logic              grow_ff;
   logic [IDX_W-1:0]  chosen_ff;
   logic [CNT_W-1:0]  j_ff;

   logic [15:0]      prev_fp_ff;
   logic [47:0]      prev_id_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] open_ff;
   logic [CNT_W-1:0] reuse_ff;
   logic [44:0]      sum_req_ff;
   logic [39:0]      sum_com_ff;
   logic             failed_ff;

   logic [47:0]      id_mem [MAX_REQUESTS];
   logic [IDX_W-1:0] asg_mem [MAX_REQUESTS];
   logic [47:0]      id_rd_ff;
   logic [IDX_W-1:0] asg_rd_ff;

   logic                     slot_wr_en, slot_rd_en;
   logic [IDX_W-1:0]         slot_wr_addr, slot_rd_addr;
   tsap_pkg::slot_entry_type slot_wr_data, slot_rd;

   logic              rsp_valid_ff;
   tsap_pkg::rsp_type rsp_word_ff;

   logic req_fire, out_free, plan_clear, check_fail, scan_hit, emit_last;
   tsap_pkg::align_type req_align, grow_align;
   logic [45:0] sum_req_next;
   logic [40:0] new_total, grow_total;
   logic [39:0] grow_na, grow_ms;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   assign req_align = tsap_pkg::align_up(req_ff.size_bytes, req_ff.alignment_bytes);
   assign sum_req_next = {1'b0, sum_req_ff} + {6'd0, req_ff.size_bytes};
   assign new_total = {1'b0, sum_com_ff} + {1'b0, committed_ff};
   assign grow_total = {1'b0, sum_com_ff} + {1'b0, delta_ff};
   assign grow_na = (slot_rd.alignment > req_ff.alignment_bytes) ? slot_rd.alignment
                                                                 : req_ff.alignment_bytes;
   assign grow_ms = (slot_rd.size > req_ff.size_bytes) ? slot_rd.size : req_ff.size_bytes;
   assign grow_align = tsap_pkg::align_up(grow_ms, grow_na);

   assign check_fail = (policy_ff == 32'd0) || (policy_ff == tsap_pkg::ALL_ONES_32)
      || (budget_ff == 40'd0) || (web_ff && aliasing_ff) || (cnt_ff >= MAX_CNT)
      || (req_ff.resource_identity == 48'd0) || (req_ff.resource_generation == 32'd0)
      || (req_ff.resource_generation == tsap_pkg::ALL_ONES_32)
      || (req_ff.compatibility_key == 32'd0) || (req_ff.first_pass > req_ff.last_pass)
      || !req_align.ok
      || ((cnt_ff != '0) && ((req_ff.first_pass < prev_fp_ff)
          || ((req_ff.first_pass == prev_fp_ff) && (req_ff.resource_identity <= prev_id_ff))))
      || sum_req_next[45];

   assign scan_hit = slot_rd.aliasable && (slot_rd.key == req_ff.compatibility_key)
                     && (slot_rd.last_pass < req_ff.first_pass);
   assign emit_last = (j_ff + CNT_W'(1)) == cnt_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsap_pkg::S_IDLE: begin
            if (req_fire) state_in = tsap_pkg::S_CHECK;
         end
         tsap_pkg::S_CHECK: begin
            if (failed_ff || check_fail) state_in = tsap_pkg::S_END;
            else state_in = tsap_pkg::S_DUP_RD;
         end
         tsap_pkg::S_DUP_RD: begin
            if (j_ff != cnt_ff) state_in = tsap_pkg::S_DUP_CMP;
            else if (aliasing_ff && req_ff.allow_alias) state_in = tsap_pkg::S_SCAN_RD;
            else state_in = tsap_pkg::S_NEW;
         end
         tsap_pkg::S_DUP_CMP: begin
            if (id_rd_ff == req_ff.resource_identity) state_in = tsap_pkg::S_END;
            else state_in = tsap_pkg::S_DUP_RD;
         end
         tsap_pkg::S_SCAN_RD: begin
            if (j_ff == open_ff) state_in = tsap_pkg::S_NEW;
            else state_in = tsap_pkg::S_SCAN_CMP;
         end
         tsap_pkg::S_SCAN_CMP: begin
            if (scan_hit) state_in = tsap_pkg::S_GROW_A;
            else state_in = tsap_pkg::S_SCAN_RD;
         end
         tsap_pkg::S_NEW: begin
            if ((open_ff >= MAX_CNT) || (new_total > {1'b0, budget_ff}))
               state_in = tsap_pkg::S_END;
            else state_in = tsap_pkg::S_COMMIT;
         end
         tsap_pkg::S_GROW_A: begin
            if (!grow_align.ok) state_in = tsap_pkg::S_END;
            else state_in = tsap_pkg::S_GROW_B;
         end
         tsap_pkg::S_GROW_B: state_in = tsap_pkg::S_GROW_C;
         tsap_pkg::S_GROW_C: begin
            if (grow_ff && (grow_total > {1'b0, budget_ff})) state_in = tsap_pkg::S_END;
            else state_in = tsap_pkg::S_COMMIT;
         end
         tsap_pkg::S_COMMIT: state_in = tsap_pkg::S_END;
         tsap_pkg::S_END: begin
            if (!req_ff.last_of_plan) state_in = tsap_pkg::S_IDLE;
            else if (failed_ff || (cnt_ff == '0)) state_in = tsap_pkg::S_FAIL_OUT;
            else state_in = tsap_pkg::S_EMIT_RD;
         end
         tsap_pkg::S_FAIL_OUT: begin
            if (out_free) state_in = tsap_pkg::S_IDLE;
         end
         tsap_pkg::S_EMIT_RD: state_in = tsap_pkg::S_EMIT_SZ;
         tsap_pkg::S_EMIT_SZ: state_in = tsap_pkg::S_EMIT_OUT;
         tsap_pkg::S_EMIT_OUT: begin
            if (out_free) begin
               if (emit_last) state_in = tsap_pkg::S_IDLE;
               else state_in = tsap_pkg::S_EMIT_RD;
            end
         end
         default: state_in = tsap_pkg::S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall = 1'b1;
      slot_rd_en = 1'b0;
      slot_rd_addr = j_ff[IDX_W-1:0];
      slot_wr_en = 1'b0;
      slot_wr_addr = chosen_ff;
      slot_wr_data = slot_rd;
      plan_clear = 1'b0;
      case (state_ff)
         tsap_pkg::S_IDLE: begin
            req_stall = 1'b0;
            plan_clear = req_fire && req_word.first_of_plan;
         end
         tsap_pkg::S_SCAN_RD: begin
            slot_rd_en = (j_ff != open_ff);
         end
         tsap_pkg::S_NEW: begin
            slot_wr_en = (open_ff < MAX_CNT) && (new_total <= {1'b0, budget_ff});
            slot_wr_addr = open_ff[IDX_W-1:0];
            slot_wr_data.key = req_ff.compatibility_key;
            slot_wr_data.size = committed_ff;
            slot_wr_data.alignment = req_ff.alignment_bytes;
            slot_wr_data.last_pass = req_ff.last_pass;
            slot_wr_data.aliasable = req_ff.allow_alias;
         end
         tsap_pkg::S_GROW_C: begin
            slot_wr_en = !(grow_ff && (grow_total > {1'b0, budget_ff}));
            slot_wr_data.last_pass = req_ff.last_pass;
            if (grow_ff) begin
               slot_wr_data.size = ns_ff;
               slot_wr_data.alignment = na_ff;
            end
         end
         tsap_pkg::S_FAIL_OUT: begin
            plan_clear = out_free;
         end
         tsap_pkg::S_EMIT_SZ: begin
            slot_rd_en = 1'b1;
            slot_rd_addr = asg_rd_ff;
         end
         tsap_pkg::S_EMIT_OUT: begin
            plan_clear = out_free && emit_last;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   tsap_slot_mem #(
      .DEPTH(MAX_REQUESTS),
      .IDX_W(IDX_W)
   ) u_slot_mem (
      .clock  (clock),
      .wr_en  (slot_wr_en),
      .wr_addr(slot_wr_addr),
      .wr_data(slot_wr_data),
      .rd_en  (slot_rd_en),
      .rd_addr(slot_rd_addr),
      .rd_data(slot_rd)
   );

   // Identity and slot-assignment tables.
   always_ff @(posedge clock) begin
      if (state_ff == tsap_pkg::S_COMMIT) begin
         id_mem[cnt_ff[IDX_W-1:0]] <= req_ff.resource_identity;
         asg_mem[cnt_ff[IDX_W-1:0]] <= chosen_ff;
      end
      if ((state_ff == tsap_pkg::S_DUP_RD) && (j_ff != cnt_ff)) begin
         id_rd_ff <= id_mem[j_ff[IDX_W-1:0]];
      end
      if (state_ff == tsap_pkg::S_EMIT_RD) begin
         asg_rd_ff <= asg_mem[j_ff[IDX_W-1:0]];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         aliasing_ff <= 1'b0;
         web_ff <= 1'b0;
         policy_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsap_pkg::CSR_BUDGET:   budget_ff <= csr_wdata;
            tsap_pkg::CSR_ALIASING: aliasing_ff <= csr_wdata[0];
            tsap_pkg::CSR_WEB:      web_ff <= csr_wdata[0];
            tsap_pkg::CSR_POLICY:   policy_ff <= csr_wdata[31:0];
            default:                policy_ff <= policy_ff;
         endcase
      end
   end

   // Sequencer state and plan totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsap_pkg::S_IDLE;
         prev_fp_ff <= '0;
         prev_id_ff <= '0;
         cnt_ff <= '0;
         open_ff <= '0;
         reuse_ff <= '0;
         sum_req_ff <= '0;
         sum_com_ff <= '0;
         failed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (plan_clear) begin
            prev_fp_ff <= '0;
            prev_id_ff <= '0;
            cnt_ff <= '0;
            open_ff <= '0;
            reuse_ff <= '0;
            sum_req_ff <= '0;
            sum_com_ff <= '0;
            failed_ff <= 1'b0;
         end else begin
            case (state_ff)
               tsap_pkg::S_CHECK: begin
                  if (!failed_ff) begin
                     if (check_fail) failed_ff <= 1'b1;
                     else sum_req_ff <= sum_req_next[44:0];
                  end
               end
               tsap_pkg::S_DUP_CMP: begin
                  if (id_rd_ff == req_ff.resource_identity) failed_ff <= 1'b1;
               end
               tsap_pkg::S_NEW: begin
                  if (slot_wr_en) begin
                     open_ff <= open_ff + CNT_W'(1);
                     sum_com_ff <= new_total[39:0];
                  end else begin
                     failed_ff <= 1'b1;
                  end
               end
               tsap_pkg::S_GROW_A: begin
                  if (!grow_align.ok) failed_ff <= 1'b1;
               end
               tsap_pkg::S_GROW_C: begin
                  if (slot_wr_en) begin
                     reuse_ff <= reuse_ff + CNT_W'(1);
                     if (grow_ff) sum_com_ff <= grow_total[39:0];
                  end else begin
                     failed_ff <= 1'b1;
                  end
               end
               tsap_pkg::S_COMMIT: begin
                  prev_fp_ff <= req_ff.first_pass;
                  prev_id_ff <= req_ff.resource_identity;
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
               default: begin
                  failed_ff <= failed_ff;
               end
            endcase
         end
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         tsap_pkg::S_IDLE: begin
            if (req_fire) req_ff <= req_word;
         end
         tsap_pkg::S_CHECK: begin
            committed_ff <= req_align.value;
            j_ff <= '0;
         end
         tsap_pkg::S_DUP_RD: begin
            if (j_ff == cnt_ff) j_ff <= '0;
         end
         tsap_pkg::S_DUP_CMP: j_ff <= j_ff + CNT_W'(1);
         tsap_pkg::S_SCAN_CMP: begin
            chosen_ff <= j_ff[IDX_W-1:0];
            j_ff <= j_ff + CNT_W'(1);
         end
         tsap_pkg::S_NEW: chosen_ff <= open_ff[IDX_W-1:0];
         tsap_pkg::S_GROW_A: begin
            ns_ff <= grow_align.value;
            na_ff <= grow_na;
         end
         tsap_pkg::S_GROW_B: begin
            grow_ff <= ns_ff > slot_rd.size;
            delta_ff <= ns_ff - slot_rd.size;
         end
         tsap_pkg::S_END: j_ff <= '0;
         tsap_pkg::S_EMIT_OUT: begin
            if (out_free) j_ff <= j_ff + CNT_W'(1);
         end
         default: begin
            j_ff <= j_ff;
         end
      endcase
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (((state_ff == tsap_pkg::S_FAIL_OUT) || (state_ff == tsap_pkg::S_EMIT_OUT))
                   && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == tsap_pkg::S_FAIL_OUT) && out_free) begin
         rsp_word_ff <= '{last_row: 1'b1, default: '0};
      end else if ((state_ff == tsap_pkg::S_EMIT_OUT) && out_free) begin
         rsp_word_ff.request_index <= 5'(j_ff);
         rsp_word_ff.slot_index <= 5'(asg_rd_ff);
         rsp_word_ff.committed_size <= slot_rd.size;
         rsp_word_ff.plan_ok <= 1'b1;
         rsp_word_ff.outcome <= !aliasing_ff ? tsap_pkg::OUTCOME_MANAGED :
                                (reuse_ff != '0) ? tsap_pkg::OUTCOME_ALIAS :
                                tsap_pkg::OUTCOME_DISJOINT;
         rsp_word_ff.slot_count <= 6'(open_ff);
         rsp_word_ff.alias_count <= 6'(reuse_ff);
         rsp_word_ff.requested_bytes <= sum_req_ff;
         rsp_word_ff.peak_bytes <= sum_com_ff;
         rsp_word_ff.last_row <= emit_last;
      end
   end

   // Every committed request either opened a slot or reused one; a slot may be open
   // for the request still being committed.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, open_ff} + {1'b0, reuse_ff}) <= ({1'b0, cnt_ff} + {{CNT_W{1'b0}}, 1'b1}))
      else $error("slot and reuse counts exceed committed requests");

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= MAX_CNT)
      else $error("request count beyond table depth");

   // A failure word carries no plan totals.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.plan_ok) |->
         (rsp_word_ff.last_row && (rsp_word_ff.slot_count == 6'd0)))
      else $error("failure word carries plan data");

   // Plan state is cleared once the last word of a plan has been loaded.
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == tsap_pkg::S_EMIT_OUT) && $past(out_free) && $past(emit_last))
         |-> (cnt_ff == '0) && !failed_ff)
      else $error("plan state not cleared after output run");

endmodule
